/* rtl/nsfe_pkg.sv */
// Shared types and codes for the nesting-level stack.
`timescale 1ns / 1ps
`default_nettype none

package nsfe_pkg;

	typedef enum logic [1:0] {
		OP_PUSH     = 2'd0,
		OP_POP      = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_ESTIMATE = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	localparam logic [3:0] LVL_NONE  = 4'd0;
	localparam logic [3:0] LVL_IF    = 4'd1;
	localparam logic [3:0] LVL_CASE  = 4'd2;
	localparam logic [3:0] LVL_CCASE = 4'd3;
	localparam logic [3:0] LVL_LOOP  = 4'd4;
	localparam logic [3:0] LVL_DEFER = 4'd5;

	localparam logic [31:0] FREQ_ONE = 32'd1;

	// shift control common to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctl_t;

	// search/estimate token walking the cell row
	typedef struct packed {
		logic        vld;
		logic        est;
		logic [3:0]  level;
		logic        found;
		logic [31:0] freq;
	} tok_t;

endpackage

`default_nettype wire

/* rtl/nsfe_cell.sv */
// One stack cell: holds one entry and applies it to a passing token.
`timescale 1ns / 1ps
`default_nettype none

module nsfe_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nsfe_pkg::stack_ctl_t ctl,
	input  wire logic [3:0]         entry_above,
	input  wire logic               live_above,
	input  wire logic [3:0]         entry_below,
	input  wire logic               live_below,
	input  wire nsfe_pkg::tok_t     tok_in,
	output logic [3:0]              entry,
	output logic                    live,
	output nsfe_pkg::tok_t          tok_out
);

	logic [3:0]     entry_q;
	logic           live_q;
	nsfe_pkg::tok_t tok_q;
	nsfe_pkg::tok_t tok_nx;

	// push moves everything one cell away from the top, pop one cell towards it
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= entry_above;
		end else if (ctl.pop) begin
			entry_q <= entry_below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctl.push) begin
			live_q <= live_above;
		end else if (ctl.pop) begin
			live_q <= live_below;
		end
	end

	always_comb begin
		tok_nx = tok_in;
		if (tok_in.vld && live_q) begin
			if (tok_in.est) begin
				case (entry_q)
					nsfe_pkg::LVL_IF: begin
						if (tok_in.freq != nsfe_pkg::FREQ_ONE) begin
							tok_nx.freq = tok_in.freq >> 1;
						end
					end
					nsfe_pkg::LVL_CASE, nsfe_pkg::LVL_CCASE: begin
						if (tok_in.freq[31:3] != 29'd0) begin
							tok_nx.freq = tok_in.freq >> 3;
						end
					end
					nsfe_pkg::LVL_LOOP: begin
						// x10 as x8 + x2, wraps at 32 bits
						tok_nx.freq = (tok_in.freq << 3) + (tok_in.freq << 1);
					end
					nsfe_pkg::LVL_DEFER: begin
						tok_nx.freq = nsfe_pkg::FREQ_ONE;
					end
					default: begin
						tok_nx.freq = tok_in.freq;
					end
				endcase
			end else if (entry_q == tok_in.level) begin
				tok_nx.found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	assign entry   = entry_q;
	assign live    = live_q;
	assign tok_out = tok_q;

endmodule

`default_nettype wire

/* rtl/nesting_stack_frequency_estimator.sv */
// Top level: nesting-level stack built as a row of shifting cells.
`timescale 1ns / 1ps
`default_nettype none

// LIFO stack of DEPTH 4-bit nesting-level codes held in a row of cells; cell 0 is
// the top and push/pop shift the whole row by one place. The result of a push or
// pop is registered at the accepting edge. Contains and estimate send a token from
// the bottom cell to the top cell, one cell per cycle, and their result is loaded
// when the token leaves the top cell; input stays blocked until the result is
// loaded. The length of the cell row sets how long the walk takes. One request is
// in progress at a time. No clearing pass is needed after reset.
module nesting_stack_frequency_estimator #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [3:0]  level,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       level_out,
	output logic             found,
	output logic [31:0]      frequency,
	output logic             empty_res,
	output logic             overflow,
	output logic [4:0]       entry_count
);

	localparam int CW = $clog2(DEPTH + 1);

	nsfe_pkg::state_t     state_q, state_nx;
	nsfe_pkg::op_t        op_in;
	nsfe_pkg::stack_ctl_t ctl;
	nsfe_pkg::tok_t       tok_inj;
	nsfe_pkg::tok_t       tok_o [DEPTH];
	logic [3:0]           ent [DEPTH];
	logic                 live [DEPTH];

	logic [CW-1:0] count_q, count_nx;
	logic          acc, is_walk, full, nonempty, load;
	logic [3:0]    top_lvl, res_level;
	logic          res_found, res_ovf;
	logic [31:0]   res_freq;

	logic          out_valid_q;
	logic [3:0]    level_out_q;
	logic          found_q, empty_q, ovf_q;
	logic [31:0]   freq_q;
	logic [4:0]    count_out_q;

	assign op_in    = nsfe_pkg::op_t'(op);
	assign acc      = in_valid && in_ready;
	assign is_walk  = (op_in == nsfe_pkg::OP_CONTAINS) || (op_in == nsfe_pkg::OP_ESTIMATE);
	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign top_lvl  = nonempty ? ent[0] : nsfe_pkg::LVL_NONE;

	assign ctl.push = acc && (op_in == nsfe_pkg::OP_PUSH) && !full;
	assign ctl.pop  = acc && (op_in == nsfe_pkg::OP_POP) && nonempty;

	always_comb begin
		tok_inj.vld   = acc && is_walk;
		tok_inj.est   = (op_in == nsfe_pkg::OP_ESTIMATE);
		tok_inj.level = level;
		tok_inj.found = 1'b0;
		tok_inj.freq  = nsfe_pkg::FREQ_ONE;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [3:0]     e_above, e_below;
		logic           l_above, l_below;
		nsfe_pkg::tok_t t_in;

		if (i == 0) begin : g_top
			assign e_above = level;
			assign l_above = 1'b1;
		end else begin : g_mid
			assign e_above = ent[i-1];
			assign l_above = live[i-1];
		end

		if (i == DEPTH - 1) begin : g_bot
			assign e_below = nsfe_pkg::LVL_NONE;
			assign l_below = 1'b0;
			assign t_in    = tok_inj;
		end else begin : g_up
			assign e_below = ent[i+1];
			assign l_below = live[i+1];
			assign t_in    = tok_o[i+1];
		end

		nsfe_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.entry_above(e_above),
			.live_above (l_above),
			.entry_below(e_below),
			.live_below (l_below),
			.tok_in     (t_in),
			.entry      (ent[i]),
			.live       (live[i]),
			.tok_out    (tok_o[i])
		);
	end

	always_comb begin
		count_nx = count_q;
		if (ctl.push) begin
			count_nx = count_q + CW'(1);
		end else if (ctl.pop) begin
			count_nx = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nx;
		end
	end

	// control
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			nsfe_pkg::ST_IDLE: begin
				if (acc && is_walk) begin
					state_nx = nsfe_pkg::ST_WALK;
				end
			end
			nsfe_pkg::ST_WALK: begin
				if (tok_o[0].vld) begin
					state_nx = nsfe_pkg::ST_IDLE;
				end
			end
			default: state_nx = nsfe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			nsfe_pkg::ST_IDLE: in_ready = !out_valid_q || out_ready;
			nsfe_pkg::ST_WALK: in_ready = 1'b0;
			default:           in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// result selection: token exit or a push/pop request
	always_comb begin
		res_found = 1'b0;
		res_freq  = '0;
		res_ovf   = 1'b0;
		res_level = top_lvl;
		if (tok_o[0].vld) begin
			res_found = tok_o[0].found && !tok_o[0].est;
			res_freq  = tok_o[0].est ? tok_o[0].freq : 32'd0;
		end else if (op_in == nsfe_pkg::OP_PUSH) begin
			res_ovf   = full;
			res_level = full ? top_lvl : level;
		end
	end

	assign load = (acc && !is_walk) || tok_o[0].vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_out_q <= res_level;
			found_q     <= res_found;
			freq_q      <= res_freq;
			empty_q     <= (count_nx == '0);
			ovf_q       <= res_ovf;
			count_out_q <= 5'(count_nx);
		end
	end

	assign out_valid   = out_valid_q;
	assign level_out   = level_out_q;
	assign found       = found_q;
	assign frequency   = freq_q;
	assign empty_res   = empty_q;
	assign overflow    = ovf_q;
	assign entry_count = count_out_q;

	a_tok_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok_o[0].vld |-> state_q == nsfe_pkg::ST_WALK)
		else $error("token left the cell row outside a walk");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_top_live: assert property (@(posedge clk) disable iff (!arst_n)
		live[0] == nonempty)
		else $error("top cell live bit disagrees with entry count");

	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_walk) |=> !in_ready)
		else $error("request taken while a search is in progress");

endmodule

`default_nettype wire

/* tb/tb_nesting_stack_frequency_estimator.sv */
// Testbench for the nesting-level stack: random push/pop/search/estimate traffic with a scoreboard.
`timescale 1ns / 1ps

module tb_nesting_stack_frequency_estimator;
	import nsfe_pkg::*;

	localparam int          DEPTH          = 16;
	localparam int unsigned RANDOM_REQS    = 900;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 2 * DEPTH + 8;
	localparam logic [31:0] LOOP_SCALE     = 32'd10;

	typedef struct {
		op_t        op;
		logic [3:0] level;
	} stack_req_t;

	typedef struct packed {
		logic [3:0]  level_out;
		logic        found;
		logic [31:0] frequency;
		logic        empty_res;
		logic        overflow;
		logic [4:0]  entry_count;
	} stack_outcome_t;

	typedef enum int unsigned {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED,
		PH_LOOPY
	} phase_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_PUSH;
	logic [3:0]  level = LVL_NONE;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  level_out;
	logic        found;
	logic [31:0] frequency;
	logic        empty_res;
	logic        overflow;
	logic [4:0]  entry_count;

	// shadow stack, index 0 is the bottom
	logic [3:0]  lvl_stack [DEPTH];
	int unsigned stack_fill = 0;

	stack_req_t     pending_reqs[$];
	stack_outcome_t pending_outcomes[$];

	bit          req_taken = 1'b0;
	bit          res_taken = 1'b0;
	bit          req_quiet = 1'b0;
	bit          res_quiet = 1'b0;
	int unsigned req_gap = 0;
	int unsigned res_stall = 0;
	int unsigned idle_cycles = 0;
	int unsigned err_count = 0;
	int unsigned n_op [4] = '{0, 0, 0, 0};
	int unsigned n_overflow = 0;
	int unsigned n_found = 0;
	int unsigned n_results = 0;
	int unsigned deepest = 0;

	nesting_stack_frequency_estimator #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.level       (level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level_out   (level_out),
		.found       (found),
		.frequency   (frequency),
		.empty_res   (empty_res),
		.overflow    (overflow),
		.entry_count (entry_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bottom-to-top walk starting from one
	function automatic logic [31:0] walk_frequency();
		logic [31:0] f = FREQ_ONE;
		for (int unsigned i = 0; i < stack_fill; i++) begin
			case (lvl_stack[i])
				LVL_IF: begin
					if (f != FREQ_ONE)
						f = f >> 1;
				end
				LVL_CASE, LVL_CCASE: begin
					if ((f >> 3) != 0)
						f = f >> 3;
				end
				LVL_LOOP:  f = f * LOOP_SCALE;
				LVL_DEFER: f = FREQ_ONE;
				default: ;
			endcase
		end
		return f;
	endfunction

	function automatic stack_outcome_t predict_stack_op(op_t o, logic [3:0] l);
		stack_outcome_t res = '0;
		logic [3:0]     popped = LVL_NONE;
		case (o)
			OP_PUSH: begin
				if (stack_fill >= DEPTH) begin
					res.overflow = 1'b1;
					n_overflow++;
				end else begin
					lvl_stack[stack_fill] = l;
					stack_fill++;
				end
			end
			OP_POP: begin
				if (stack_fill != 0) begin
					stack_fill--;
					popped = lvl_stack[stack_fill];
				end
			end
			OP_CONTAINS: begin
				for (int unsigned i = 0; i < stack_fill; i++)
					if (lvl_stack[i] == l)
						res.found = 1'b1;
				if (res.found)
					n_found++;
			end
			default: res.frequency = walk_frequency();
		endcase
		if (o == OP_POP)
			res.level_out = popped;
		else
			res.level_out = (stack_fill == 0) ? LVL_NONE : lvl_stack[stack_fill - 1];
		res.empty_res   = (stack_fill == 0);
		res.entry_count = 5'(stack_fill);
		if (stack_fill > deepest)
			deepest = stack_fill;
		return res;
	endfunction

	// mostly short gaps, a few long ones; none while quiet
	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r = $urandom_range(99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns  mismatch: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	task automatic add_req(op_t o, logic [3:0] l);
		stack_req_t r;
		r.op    = o;
		r.level = l;
		pending_reqs.push_back(r);
	endtask

	// request driver
	always @(negedge clk) begin : drive_req
		stack_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (req_gap > 0) begin
				in_valid <= 1'b0;
				req_gap--;
			end else if (pending_reqs.size() > 0) begin
				nxt = pending_reqs.pop_front();
				in_valid <= 1'b1;
				op <= nxt.op;
				level <= nxt.level;
				req_gap = pick_gap(req_quiet);
				if ($urandom_range(59) == 0)
					req_quiet = !req_quiet;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (res_taken && res_stall == 0) begin
				res_stall = pick_gap(res_quiet);
				if ($urandom_range(59) == 0)
					res_quiet = !res_quiet;
			end
			if (res_stall > 0) begin
				out_ready <= 1'b0;
				res_stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: results are checked before this edge's request is predicted, as results are
	// registered and can never belong to the request taken on the same edge
	always @(posedge clk) begin : watch
		stack_outcome_t want;
		req_taken = arst_n && in_valid && in_ready;
		res_taken = arst_n && out_valid && out_ready;
		if (res_taken) begin
			n_results++;
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("result with no request pending, level_out", level_out, 0);
			end else begin
				want = pending_outcomes.pop_front();
				if (level_out !== want.level_out)
					flag_mismatch("level_out", level_out, want.level_out);
				if (found !== want.found)
					flag_mismatch("found", found, want.found);
				if (frequency !== want.frequency)
					flag_mismatch("frequency", frequency, want.frequency);
				if (empty_res !== want.empty_res)
					flag_mismatch("empty_res", empty_res, want.empty_res);
				if (overflow !== want.overflow)
					flag_mismatch("overflow", overflow, want.overflow);
				if (entry_count !== want.entry_count)
					flag_mismatch("entry_count", entry_count, want.entry_count);
			end
		end
		if (req_taken) begin
			pending_outcomes.push_back(predict_stack_op(op_t'(op), level));
			n_op[op]++;
		end
		idle_cycles = (req_taken || res_taken) ? 0 : idle_cycles + 1;
	end

	initial begin
		int unsigned n;
		int unsigned k;
		int unsigned len;
		int unsigned push_pct;
		phase_kind_t kind;
		op_t         o;
		logic [3:0]  l;
		bit          timed_out;

		// empty-stack corners, a pushed zero, fill to the brim, then overflow, walks of the full stack and pops
		add_req(OP_POP, 4'hF);
		add_req(OP_ESTIMATE, LVL_NONE);
		add_req(OP_CONTAINS, LVL_NONE);
		add_req(OP_PUSH, LVL_NONE);
		add_req(OP_CONTAINS, LVL_NONE);
		add_req(OP_CONTAINS, 4'd9);
		for (int i = 1; i < 16; i++)
			add_req(OP_PUSH, 4'(i));
		add_req(OP_PUSH, 4'd7);
		add_req(OP_ESTIMATE, 4'hA);
		add_req(OP_CONTAINS, 4'hF);
		add_req(OP_POP, LVL_NONE);
		add_req(OP_POP, 4'h5);

		n = 0;
		while (n < RANDOM_REQS) begin
			kind = phase_kind_t'($urandom_range(3));
			len  = $urandom_range(60, 20);
			case (kind)
				PH_FILL:  push_pct = 75;
				PH_DRAIN: push_pct = 20;
				PH_MIXED: push_pct = 45;
				default:  push_pct = 70;
			endcase
			for (k = 0; k < len && n < RANDOM_REQS; k++) begin
				if ($urandom_range(99) < push_pct) begin
					o = OP_PUSH;
					if (kind == PH_LOOPY && $urandom_range(3) != 0)
						l = LVL_LOOP;
					else if ($urandom_range(99) < 65)
						l = 4'($urandom_range(5, 1));
					else
						l = 4'($urandom_range(15));
				end else begin
					case ($urandom_range(2))
						0:       o = OP_POP;
						1:       o = OP_CONTAINS;
						default: o = OP_ESTIMATE;
					endcase
					l = 4'($urandom_range(15));
				end
				add_req(o, l);
				n++;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(pending_reqs.size() == 0 && !in_valid && pending_outcomes.size() == 0) &&
				idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		timed_out = (idle_cycles >= WATCHDOG_LIMIT);
		if (!timed_out)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (timed_out) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending_outcomes.size());
			$display("*** FAILED ***");
		end else begin
			$display("ran %0d push, %0d pop, %0d contains, %0d estimate requests; %0d results",
				n_op[OP_PUSH], n_op[OP_POP], n_op[OP_CONTAINS], n_op[OP_ESTIMATE], n_results);
			$display("overflow hits %0d, contains hits %0d, deepest fill %0d, mismatches %0d",
				n_overflow, n_found, deepest, err_count);
			if (err_count == 0)
				$display("*** PASSED ***");
			else
				$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/nsfe_pkg.sv
rtl/nsfe_cell.sv
rtl/nesting_stack_frequency_estimator.sv
tb/tb_nesting_stack_frequency_estimator.sv
